>>> hdl/hdlc_pkg.sv
// ----------------------------------------------------------------------------
// hdlc_pkg
// Shared types and constants for the half-duplex link controller.
// ----------------------------------------------------------------------------
package hdlc_pkg;

    // Width of the wrapping statistics counters
    localparam int COUNT_WIDTH = 16;

    // Configuration register indexes
    localparam logic REG_FRAME_LIMIT  = 1'b0;
    localparam logic REG_RESEND_LIMIT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] FRAME_LIMIT_RESET  = 8'd10;
    localparam logic [3:0] RESEND_LIMIT_RESET = 4'd3;

    // Raw command codes on the input channel
    typedef enum logic [3:0] {
        CMD_ENQ        = 4'd0,
        CMD_EOT        = 4'd1,
        CMD_ACK0       = 4'd2,
        CMD_ACK1       = 4'd3,
        CMD_NAK        = 4'd4,
        CMD_DATA       = 4'd5,
        CMD_TIMEOUT    = 4'd6,
        CMD_SEND_REQ   = 4'd7,
        CMD_IDLE_TICK  = 4'd8,
        CMD_CONNECT    = 4'd9,
        CMD_DISCONNECT = 4'd10,
        CMD_NONE       = 4'd11
    } cmd_t;

    // Classified link events, as held in the queue
    typedef enum logic [3:0] {
        EV_ENQ,
        EV_EOT,
        EV_ACK,
        EV_NAK,
        EV_DATA_GOOD,
        EV_DATA_BAD,
        EV_TIMEOUT,
        EV_SEND_REQ,
        EV_IDLE_TICK,
        EV_CONNECT,
        EV_DISCONNECT,
        EV_NONE
    } event_t;

    // Frame to transmit
    typedef enum logic [2:0] {
        TX_NONE    = 3'd0,
        TX_ACK0    = 3'd1,
        TX_ENQ     = 3'd2,
        TX_NAK     = 3'd3,
        TX_ACK_SEQ = 3'd4,
        TX_DATA    = 3'd5,
        TX_EOT     = 3'd6
    } tx_kind_t;

    // Link state
    typedef enum logic [2:0] {
        LS_DISCONNECTED = 3'd0,
        LS_IDLE         = 3'd1,
        LS_BIDDING      = 3'd2,
        LS_SENDING      = 3'd3,
        LS_BACKOFF      = 3'd4,
        LS_RECEIVING    = 3'd5
    } link_state_t;

    // Input transaction payload
    typedef struct packed {
        logic [3:0] cmd;
        logic       frame_good;
        logic       seq_bit;
        logic       have_data;
    } in_item_t;

    // Classified entry between front and back
    typedef struct packed {
        event_t ev;
        logic   seq_bit;
        logic   have_data;
    } evt_item_t;

    // Result transaction payload
    typedef struct packed {
        tx_kind_t                 send_kind;
        logic                     send_seq;
        logic                     pop_head;
        logic                     deliver;
        link_state_t              link_state;
        logic [COUNT_WIDTH-1:0]   sent_count;
        logic [COUNT_WIDTH-1:0]   resend_count;
        logic [COUNT_WIDTH-1:0]   good_count;
        logic [COUNT_WIDTH-1:0]   bad_count;
        logic [COUNT_WIDTH-1:0]   dup_count;
    } out_item_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [7:0] frame_limit;
        logic [3:0] resend_limit;
    } cfg_t;

endpackage

>>> hdl/hdlc_regs.sv
// ----------------------------------------------------------------------------
// hdlc_regs
// APB-style configuration registers: frame limit per turn and resend limit.
// ----------------------------------------------------------------------------
module hdlc_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output hdlc_pkg::cfg_t    cfg
);
    import hdlc_pkg::*;

    logic [7:0] frame_limit_reg;
    logic [3:0] resend_limit_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_limit_reg  <= FRAME_LIMIT_RESET;
            resend_limit_reg <= RESEND_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FRAME_LIMIT:  frame_limit_reg  <= pwdata[7:0];
                REG_RESEND_LIMIT: resend_limit_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_FRAME_LIMIT:  prdata = {24'd0, frame_limit_reg};
            REG_RESEND_LIMIT: prdata = {28'd0, resend_limit_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.frame_limit  = frame_limit_reg;
    assign cfg.resend_limit = resend_limit_reg;

endmodule

>>> hdl/hdlc_front.sv
// ----------------------------------------------------------------------------
// hdlc_front
// Front end: takes input transactions and classifies the raw command into
// a link event, folding the integrity flag into data events.
// ----------------------------------------------------------------------------
module hdlc_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hdlc_pkg::in_item_t    s_data,
    output logic                  push,
    output hdlc_pkg::evt_item_t   push_item,
    input  logic                  q_full
);
    import hdlc_pkg::*;

    event_t ev;

    assign s_ready = ~q_full;
    assign push    = s_valid & ~q_full;

    // Command decode; unused codes count as no event
    always_comb begin
        unique case (s_data.cmd)
            CMD_ENQ:        ev = EV_ENQ;
            CMD_EOT:        ev = EV_EOT;
            CMD_ACK0,
            CMD_ACK1:       ev = EV_ACK;
            CMD_NAK:        ev = EV_NAK;
            CMD_DATA:       ev = s_data.frame_good ? EV_DATA_GOOD : EV_DATA_BAD;
            CMD_TIMEOUT:    ev = EV_TIMEOUT;
            CMD_SEND_REQ:   ev = EV_SEND_REQ;
            CMD_IDLE_TICK:  ev = EV_IDLE_TICK;
            CMD_CONNECT:    ev = EV_CONNECT;
            CMD_DISCONNECT: ev = EV_DISCONNECT;
            default:        ev = EV_NONE;
        endcase
    end

    assign push_item.ev        = ev;
    assign push_item.seq_bit   = s_data.seq_bit;
    assign push_item.have_data = s_data.have_data;

endmodule

>>> hdl/hdlc_queue.sv
// ----------------------------------------------------------------------------
// hdlc_queue
// Two-entry event queue between front and back end. Push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module hdlc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hdlc_pkg::evt_item_t   push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  q_valid,
    output hdlc_pkg::evt_item_t   head
);
    import hdlc_pkg::*;

    evt_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/hdlc_back.sv
// ----------------------------------------------------------------------------
// hdlc_back
// Back end: link state machine, turn and resend tallies, statistics
// counters and the result register.
// ----------------------------------------------------------------------------
module hdlc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hdlc_pkg::cfg_t        cfg,
    input  logic                  q_valid,
    input  hdlc_pkg::evt_item_t   head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hdlc_pkg::out_item_t   m_data
);
    import hdlc_pkg::*;

    localparam int C_SENT   = 0;
    localparam int C_RESEND = 1;
    localparam int C_GOOD   = 2;
    localparam int C_BAD    = 3;
    localparam int C_DUP    = 4;

    link_state_t            mode_reg, mode_next;
    logic [7:0]             frames_reg, frames_next;
    logic [4:0]             resend_reg, resend_next;
    logic                   last_seq_reg, last_seq_next;
    logic [COUNT_WIDTH-1:0] stat_reg [5];
    logic [COUNT_WIDTH-1:0] stat_next [5];
    logic [4:0]             bump;
    out_item_t              out_reg, out_next;
    logic                   out_valid_reg;

    tx_kind_t kind;
    logic     seq;
    logic     pop_head;
    logic     dlv;
    logic     try_send;

    // Take a new event whenever the result slot is free or being emptied
    assign pop     = q_valid & (~out_valid_reg | m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Next state and outputs
    always_comb begin
        mode_next     = mode_reg;
        frames_next   = frames_reg;
        resend_next   = resend_reg;
        last_seq_next = last_seq_reg;
        kind          = TX_NONE;
        seq           = 1'b0;
        pop_head      = 1'b0;
        dlv           = 1'b0;
        bump          = 5'd0;
        try_send      = 1'b0;

        if (head.ev == EV_DISCONNECT) begin
            mode_next = LS_DISCONNECTED;
        end else begin
            unique case (mode_reg)
                LS_DISCONNECTED: begin
                    if (head.ev == EV_CONNECT) mode_next = LS_IDLE;
                end
                LS_IDLE, LS_BACKOFF: begin
                    if (head.ev == EV_ENQ) begin
                        kind          = TX_ACK0;
                        last_seq_next = 1'b1;
                        mode_next     = LS_RECEIVING;
                    end else if (head.ev == EV_IDLE_TICK) begin
                        kind = TX_EOT;
                    end else if (head.ev == EV_TIMEOUT) begin
                        mode_next = (mode_reg == LS_IDLE) ? LS_DISCONNECTED : LS_IDLE;
                    end else if (head.ev == EV_SEND_REQ && mode_reg == LS_IDLE) begin
                        kind      = TX_ENQ;
                        mode_next = LS_BIDDING;
                    end
                end
                LS_BIDDING: begin
                    if (head.ev == EV_ACK) begin
                        frames_next = 8'd0;
                        resend_next = 5'd0;
                        try_send    = 1'b1;
                    end else if (head.ev == EV_ENQ || head.ev == EV_TIMEOUT) begin
                        mode_next = LS_BACKOFF;
                    end
                end
                LS_SENDING: begin
                    if (head.ev == EV_ACK) begin
                        resend_next    = 5'd0;
                        frames_next    = frames_reg + 8'd1;
                        pop_head       = 1'b1;
                        bump[C_SENT]   = 1'b1;
                        try_send       = 1'b1;
                    end else if (head.ev == EV_NAK || head.ev == EV_TIMEOUT) begin
                        resend_next    = resend_reg + 5'd1;
                        bump[C_RESEND] = 1'b1;
                        try_send       = 1'b1;
                    end
                end
                LS_RECEIVING: begin
                    if (head.ev == EV_DATA_BAD) begin
                        kind        = TX_NAK;
                        bump[C_BAD] = 1'b1;
                    end else if (head.ev == EV_DATA_GOOD) begin
                        if (head.seq_bit != last_seq_reg) begin
                            last_seq_next = head.seq_bit;
                            dlv           = 1'b1;
                            bump[C_GOOD]  = 1'b1;
                        end else begin
                            bump[C_DUP] = 1'b1;
                        end
                        kind = TX_ACK_SEQ;
                        seq  = last_seq_next;
                    end else if (head.ev == EV_EOT || head.ev == EV_TIMEOUT) begin
                        mode_next = LS_IDLE;
                    end
                end
                default: mode_next = LS_DISCONNECTED;
            endcase
        end

        // Send the current frame or give up the line; check on the updated tallies
        if (try_send) begin
            if ((frames_next < cfg.frame_limit)
                    && (resend_next <= {1'b0, cfg.resend_limit})
                    && head.have_data) begin
                kind      = TX_DATA;
                seq       = frames_next[0];
                mode_next = LS_SENDING;
            end else begin
                mode_next = LS_BACKOFF;
            end
        end
    end

    // Wrapping statistics
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            stat_next[i] = bump[i] ? stat_reg[i] + COUNT_WIDTH'(1) : stat_reg[i];
        end
    end

    // Result assembly
    always_comb begin
        out_next.send_kind    = kind;
        out_next.send_seq     = seq;
        out_next.pop_head     = pop_head;
        out_next.deliver      = dlv;
        out_next.link_state   = mode_next;
        out_next.sent_count   = stat_next[C_SENT];
        out_next.resend_count = stat_next[C_RESEND];
        out_next.good_count   = stat_next[C_GOOD];
        out_next.bad_count    = stat_next[C_BAD];
        out_next.dup_count    = stat_next[C_DUP];
    end

    // Link state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= LS_DISCONNECTED;
            frames_reg   <= 8'd0;
            resend_reg   <= 5'd0;
            last_seq_reg <= 1'b1;
            for (int i = 0; i < 5; i++) begin
                stat_reg[i] <= '0;
            end
        end else if (pop) begin
            mode_reg     <= mode_next;
            frames_reg   <= frames_next;
            resend_reg   <= resend_next;
            last_seq_reg <= last_seq_next;
            for (int i = 0; i < 5; i++) begin
                stat_reg[i] <= stat_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> hdl/half_duplex_link_controller.sv
// An accepted transaction is first stored in the event queue, then registered in the result
// register, from which it can be taken.
// Throughput: one transaction per cycle; a held-off result stalls the back end,
// the two-entry event queue then fills and s_ready drops until it drains.
// Reset (aresetn low, synchronous): link disconnected, tallies and counters zero,
// last received sequence 1, limits back to 10 frames and 3 resends.
// ----------------------------------------------------------------------------
// half_duplex_link_controller
// Half-duplex stop-and-wait link controller with APB configuration port.
// ----------------------------------------------------------------------------
module half_duplex_link_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hdlc_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hdlc_pkg::out_item_t   m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import hdlc_pkg::*;

    cfg_t      cfg;
    logic      push;
    evt_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    evt_item_t q_head;

    hdlc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hdlc_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hdlc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head      (q_head)
    );

    hdlc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .head    (q_head),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
